>>> sv/cdfil_pkg.sv
// Shared constants, types and lifting arithmetic for the inverse CDF 5/3 row block.
package cdfil_pkg;

  localparam int SAMPLE_WIDTH   = 16;
  localparam int MAX_HALF_WIDTH = 2048;
  localparam int MAX_ROWS       = 4096;

  localparam int FIELD_W    = 16;
  localparam int HW_REG_W   = 12;
  localparam int RC_REG_W   = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  localparam int COL_W = $clog2(MAX_HALF_WIDTH + 2);
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_EXTRA_LOW  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = CFG_IDX_W'(2);

  typedef logic signed [SAMPLE_WIDTH-1:0] smp_t;

  typedef struct packed {
    logic [HW_REG_W-1:0] half_width;
    logic                extra_low;
    logic [RC_REG_W-1:0] row_count;
  } cfg_t;

  // One column's work for the back end
  typedef struct packed {
    smp_t prev_even;
    smp_t prev_high;
    smp_t even;
    smp_t high;
    logic has_prev;
    logic final_col;
    logic extra_low;
    logic last_row;
  } cmd_t;

  function automatic smp_t even_of(smp_t lo, smp_t hl, smp_t h);
    smp_t                       s;
    logic signed [SAMPLE_WIDTH:0] t;
    s = hl + h;
    // bias negative sums so the shift truncates toward zero
    t = $signed({s[SAMPLE_WIDTH-1], s}) + $signed((SAMPLE_WIDTH+1)'(s[SAMPLE_WIDTH-1] ? 3 : 0));
    return lo - SAMPLE_WIDTH'(t >>> 2);
  endfunction

  function automatic smp_t odd_of(smp_t h, smp_t e, smp_t en);
    smp_t                       s;
    logic signed [SAMPLE_WIDTH:0] t;
    s = e + en;
    t = $signed({s[SAMPLE_WIDTH-1], s}) + $signed((SAMPLE_WIDTH+1)'(s[SAMPLE_WIDTH-1] ? 1 : 0));
    return h + SAMPLE_WIDTH'(t >>> 1);
  endfunction

endpackage

>>> sv/cdfil_front.sv
// Front end: accepts column coefficients, tracks position in the row and computes the even sample.
module cdfil_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cdfil_pkg::cfg_t        cfg_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [31:0]            s_axis_tdata,   // low_sample[15:0], high_sample[31:16]
  input  logic                   full_i,
  output logic                   push_o,
  output cdfil_pkg::cmd_t        cmd_o
);

  localparam int SW = cdfil_pkg::SAMPLE_WIDTH;
  localparam int CW = cdfil_pkg::COL_W;
  localparam int RW = cdfil_pkg::ROW_W;

  cdfil_pkg::smp_t prev_high_q, prev_high_d;
  cdfil_pkg::smp_t prev_even_q, prev_even_d;
  logic [CW-1:0]   col_q, col_d;
  logic [RW-1:0]   row_q, row_d;

  logic [CW-1:0]   hw_eff;
  logic [CW-1:0]   ncols;
  logic [CW-1:0]   col;
  logic [RW:0]     rows_eff;
  logic [RW:0]     row_next;
  logic            final_col;
  logic            accept;
  cdfil_pkg::smp_t lo, hi, hl, ev;

  assign s_axis_tready = !full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign push_o        = accept;

  always_comb begin
    if (cfg_i.half_width < cdfil_pkg::HW_REG_W'(2)) begin
      hw_eff = CW'(2);
    end else if (int'(cfg_i.half_width) > cdfil_pkg::MAX_HALF_WIDTH) begin
      hw_eff = CW'(cdfil_pkg::MAX_HALF_WIDTH);
    end else begin
      hw_eff = CW'(cfg_i.half_width);
    end
    if (cfg_i.row_count == '0) begin
      rows_eff = (RW+1)'(1);
    end else if (int'(cfg_i.row_count) > cdfil_pkg::MAX_ROWS) begin
      rows_eff = (RW+1)'(cdfil_pkg::MAX_ROWS);
    end else begin
      rows_eff = (RW+1)'(cfg_i.row_count);
    end
    ncols = hw_eff + CW'(cfg_i.extra_low);
    // saturate a stale index to the row's final item
    col       = (col_q > ncols - CW'(1)) ? ncols - CW'(1) : col_q;
    final_col = (col == ncols - CW'(1));
    row_next  = (RW+1)'(row_q) + (RW+1)'(1);

    lo = SW'($signed(s_axis_tdata[15:0]));
    hi = SW'($signed(s_axis_tdata[31:16]));
    if (cfg_i.extra_low && (col == hw_eff)) begin
      hi = '0;
    end
    hl = (col == '0) ? '0 : prev_high_q;
    ev = cdfil_pkg::even_of(lo, hl, hi);

    cmd_o.prev_even = prev_even_q;
    cmd_o.prev_high = prev_high_q;
    cmd_o.even      = ev;
    cmd_o.high      = hi;
    cmd_o.has_prev  = (col != '0);
    cmd_o.final_col = final_col;
    cmd_o.extra_low = cfg_i.extra_low;
    cmd_o.last_row  = (row_next >= rows_eff);

    prev_high_d = prev_high_q;
    prev_even_d = prev_even_q;
    col_d       = col_q;
    row_d       = row_q;
    if (accept) begin
      prev_high_d = hi;
      prev_even_d = ev;
      if (final_col) begin
        col_d = '0;
        row_d = (row_next >= rows_eff) ? '0 : row_next[RW-1:0];
      end else begin
        col_d = col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_high_q <= '0;
      prev_even_q <= '0;
      col_q       <= '0;
      row_q       <= '0;
    end else begin
      prev_high_q <= prev_high_d;
      prev_even_q <= prev_even_d;
      col_q       <= col_d;
      row_q       <= row_d;
    end
  end

  a_final_wraps_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && final_col) |=> (col_q == '0))
    else $error("column index not cleared after final item");

endmodule

>>> sv/cdfil_fifo.sv
// Short command queue between the front and back ends.
module cdfil_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cdfil_pkg::cmd_t cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output cdfil_pkg::cmd_t cmd_o
);

  localparam int AW = cdfil_pkg::FIFO_AW;
  localparam int D  = cdfil_pkg::FIFO_DEPTH;

  cdfil_pkg::cmd_t mem_q [D];
  logic [AW-1:0]   wr_q, wr_d;
  logic [AW-1:0]   rd_q, rd_d;
  logic [AW:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == (AW+1)'(D));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + AW'(1) : wr_q;
    rd_d  = pop_i ? rd_q + AW'(1) : rd_q;
    cnt_d = cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o) && !(pop_i && !valid_o))
    else $error("command queue overrun or underrun");

endmodule

>>> sv/cdfil_back.sv
// Back end: walks each command's slots; one sample per cycle unless stalled.
module cdfil_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  input  cdfil_pkg::cmd_t      cmd_i,
  output logic                 pop_o,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [15:0]          m_axis_tdata,   // sample[15:0]
  output logic                 m_axis_tlast,   // last_of_row
  output logic                 m_axis_tuser    // last_of_image
);

  localparam logic [1:0] SLOT_PREV_EVEN = 2'd0;
  localparam logic [1:0] SLOT_PREV_ODD  = 2'd1;
  localparam logic [1:0] SLOT_EVEN      = 2'd2;
  localparam logic [1:0] SLOT_MIRROR    = 2'd3;

  logic [1:0]      step_q, step_d;
  logic [1:0]      slot;
  logic            emit, last, row_end, load, advance;
  cdfil_pkg::smp_t value;

  logic            ovalid_q, ovalid_d;
  logic [15:0]     data_q, data_d;
  logic            tlast_q, tlast_d;
  logic            tuser_q, tuser_d;

  always_comb begin
    // skip the previous-column slots on a row's first column
    slot = (step_q == SLOT_PREV_EVEN && !cmd_i.has_prev) ? SLOT_EVEN : step_q;
    emit = !slot[1] || cmd_i.final_col;
    row_end = (slot == SLOT_EVEN && cmd_i.extra_low) || (slot == SLOT_MIRROR);
    last = (slot == SLOT_PREV_ODD && !cmd_i.final_col) || row_end;

    case (slot)
      SLOT_PREV_EVEN: value = cmd_i.prev_even;
      SLOT_PREV_ODD:  value = cdfil_pkg::odd_of(cmd_i.prev_high, cmd_i.prev_even, cmd_i.even);
      SLOT_EVEN:      value = cmd_i.even;
      SLOT_MIRROR:    value = cdfil_pkg::odd_of(cmd_i.high, cmd_i.even, cmd_i.even);
      default:        value = cmd_i.even;
    endcase

    load    = cmd_valid_i && emit && (!ovalid_q || m_axis_tready);
    advance = cmd_valid_i && (!emit || load);
    pop_o   = advance && (last || !emit);

    step_d = step_q;
    if (pop_o) begin
      step_d = SLOT_PREV_EVEN;
    end else if (advance) begin
      step_d = slot + 2'd1;
    end

    ovalid_d = ovalid_q;
    data_d   = data_q;
    tlast_d  = tlast_q;
    tuser_d  = tuser_q;
    if (load) begin
      ovalid_d = 1'b1;
      data_d   = value[15:0];
      tlast_d  = row_end;
      tuser_d  = row_end && cmd_i.last_row;
    end else if (m_axis_tready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= SLOT_PREV_EVEN;
      ovalid_q <= 1'b0;
    end else begin
      step_q   <= step_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    tlast_q <= tlast_d;
    tuser_q <= tuser_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tlast  = tlast_q;
  assign m_axis_tuser  = tuser_q;

  a_image_end_is_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("image end without row end");

  a_pop_needs_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> cmd_valid_i)
    else $error("pop without a queued command");

  a_step_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (step_q == SLOT_PREV_EVEN))
    else $error("slot counter not restarted after a command");

endmodule

>>> sv/cdf53_inverse_row_lifting.sv
// Inverse CDF 5/3 row lifting: configuration registers, front end, command queue, back end.
// A column's samples start once the next column is accepted; that request passes through the
// command queue and the output register before its first sample is on m_axis.
// Throughput: a request per cycle while the four-entry queue has room; the output register
// drains one sample per cycle while m_axis_tready is high. A column's command yields two
// samples, a row's final column's up to four and a row's first column's none. Reset clears
// all row state and loads the registers with half_width 8, extra_low 0, row_count 1.
module cdf53_inverse_row_lifting (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cdfil_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cdfil_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [31:0]                     s_axis_tdata,   // low_sample[15:0], high_sample[31:16]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [15:0]                     m_axis_tdata,   // sample[15:0]
  output logic                            m_axis_tlast,   // last_of_row
  output logic                            m_axis_tuser    // last_of_image
);

  cdfil_pkg::cfg_t cfg_q, cfg_d;
  cdfil_pkg::cmd_t push_cmd, head_cmd;
  logic            push, full, pop, head_valid;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        cdfil_pkg::REG_HALF_WIDTH: cfg_d.half_width = cfg_data_i[cdfil_pkg::HW_REG_W-1:0];
        cdfil_pkg::REG_EXTRA_LOW:  cfg_d.extra_low  = cfg_data_i[0];
        cdfil_pkg::REG_ROW_COUNT:  cfg_d.row_count  = cfg_data_i[cdfil_pkg::RC_REG_W-1:0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_width <= cdfil_pkg::HW_REG_W'(8);
      cfg_q.extra_low  <= 1'b0;
      cfg_q.row_count  <= cdfil_pkg::RC_REG_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  cdfil_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .full_i        (full),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  cdfil_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .cmd_o   (head_cmd)
  );

  cdfil_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (head_valid),
    .cmd_i         (head_cmd),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
